>>> src/hltc_pkg.sv
// ----------------------------------------------------------------------------
// Tile cache package
// Shared constants, payload words and divider request and response types.
// ----------------------------------------------------------------------------
package hltc_pkg;

  localparam int ENTRIES   = 256;
  localparam int BUCKETS   = 64;
  localparam int ENTRY_W   = $clog2(ENTRIES);
  localparam int BUCKET_W  = $clog2(BUCKETS);
  localparam int STEP_W    = $clog2(ENTRIES + 1);
  localparam int CLR_DEPTH = (ENTRIES > BUCKETS) ? ENTRIES : BUCKETS;
  localparam int CLR_W     = $clog2(CLR_DEPTH);
  localparam int KEY_W     = 64;
  localparam int USER_W    = 32;
  localparam int TILE_W    = 16;
  localparam int POS_W     = ((TILE_W > ENTRY_W) ? TILE_W : ENTRY_W) + 1;
  localparam int DCNT_W    = $clog2(POS_W + 1);

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  localparam logic CFG_RESERVED = 1'b0;
  localparam logic CFG_PER_ROW  = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [KEY_W-1:0]  key_low;
    logic [KEY_W-1:0]  key_high;
    logic [7:0]        target_entry;
    logic [USER_W-1:0] new_state;
    logic [USER_W-1:0] new_count;
  } in_word_t;

  typedef struct packed {
    logic [7:0]        entry_id;
    logic              was_hit;
    logic              evicted;
    logic [USER_W-1:0] fill_state;
    logic [USER_W-1:0] tile_count;
    logic [TILE_W-1:0] tile_x;
    logic [TILE_W-1:0] tile_y;
  } out_word_t;

  typedef struct packed {
    logic              start;
    logic [POS_W-1:0]  dividend;
    logic [TILE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [POS_W-1:0]  quotient;
    logic [TILE_W-1:0] remainder;
  } div_rsp_t;

endpackage

>>> src/hashed_lru_tile_cache.sv
// ----------------------------------------------------------------------------
// Hashed LRU tile cache
// Hash-chained cache of entries with LRU replacement and tile placement.
// ----------------------------------------------------------------------------
// After reset the block initializes its memories before it takes the first
// word. A write word updates the state and count of its target entry as it
// is accepted and gives no result. A lookup word probes its bucket's chain
// one entry at a time; a miss that evicts also walks the victim's chain. Every
// memory access goes through one registered read port per store, and the tile
// column and row come from a divider. One word is in work at a time, and a
// finished result waits in the output register.
module hashed_lru_tile_cache (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hltc_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hltc_pkg::out_word_t  out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_wdata
);

  typedef enum logic [22:0] {
    S_INIT     = 23'h000001,
    S_IDLE     = 23'h000002,
    S_HEADW    = 23'h000004,
    S_PROBE    = 23'h000008,
    S_CMP      = 23'h000010,
    S_HIT      = 23'h000020,
    S_UNL      = 23'h000040,
    S_MISS     = 23'h000080,
    S_FREEW    = 23'h000100,
    S_FREEN    = 23'h000200,
    S_EV0      = 23'h000400,
    S_EV1      = 23'h000800,
    S_EV2      = 23'h001000,
    S_EV3      = 23'h002000,
    S_EVWALK   = 23'h004000,
    S_EVWALKW  = 23'h008000,
    S_ALLOC    = 23'h010000,
    S_ALLOCW   = 23'h020000,
    S_MRU      = 23'h040000,
    S_MRUW     = 23'h080000,
    S_MRU2     = 23'h100000,
    S_TILE     = 23'h200000,
    S_DIVW     = 23'h400000
  } state_t;

  localparam int EW = hltc_pkg::ENTRY_W;
  localparam int BW = hltc_pkg::BUCKET_W;
  localparam int KW = hltc_pkg::KEY_W;
  localparam int UW = hltc_pkg::USER_W;

  state_t                       state_r, state_nxt;
  logic [hltc_pkg::CLR_W-1:0]   init_r, init_nxt;
  logic [15:0]                  reserved_r, reserved_nxt;
  logic [15:0]                  per_row_r, per_row_nxt;
  logic [KW-1:0]                key_lo_r, key_lo_nxt;
  logic [KW-1:0]                key_hi_r, key_hi_nxt;
  logic [BW-1:0]                bkt_r, bkt_nxt;
  logic [BW-1:0]                bkt2_r, bkt2_nxt;
  logic [EW-1:0]                e_r, e_nxt;
  logic [EW-1:0]                t_r, t_nxt;
  logic [EW-1:0]                ct_r, ct_nxt;
  logic [EW-1:0]                c_r, c_nxt;
  logic [EW-1:0]                fnext_r, fnext_nxt;
  logic [EW-1:0]                head_r, head_nxt;
  logic [hltc_pkg::STEP_W-1:0]  steps_r, steps_nxt;
  logic                         hit_r, hit_nxt;
  logic                         ev_r, ev_nxt;
  logic [UW-1:0]                us_r, us_nxt;
  logic [UW-1:0]                uc_r, uc_nxt;
  hltc_pkg::out_word_t          out_r, out_nxt;
  logic                         out_valid_r, out_valid_nxt;

  logic          bh_we, kl_we, kh_we, cn_we, rn_we, rp_we, us_we, uc_we;
  logic [BW-1:0] bh_wa, bh_ra;
  logic [EW-1:0] bh_wd, bh_q;
  logic [EW-1:0] kl_wa, kl_ra, kh_wa, kh_ra;
  logic [KW-1:0] kl_wd, kl_q, kh_wd, kh_q;
  logic [EW-1:0] cn_wa, cn_ra, cn_wd, cn_q;
  logic [EW-1:0] rn_wa, rn_ra, rn_wd, rn_q;
  logic [EW-1:0] rp_wa, rp_ra, rp_wd, rp_q;
  logic [EW-1:0] us_wa, us_ra, uc_wa, uc_ra;
  logic [UW-1:0] us_wd, us_q, uc_wd, uc_q;

  hltc_pkg::div_req_t div_req;
  hltc_pkg::div_rsp_t div_rsp;

  hltc_ram #(.WIDTH(EW), .DEPTH(hltc_pkg::BUCKETS)) u_bh (
    .clk(clk), .we(bh_we), .waddr(bh_wa), .wdata(bh_wd), .raddr(bh_ra), .rdata(bh_q));
  hltc_ram #(.WIDTH(KW), .DEPTH(hltc_pkg::ENTRIES)) u_kl (
    .clk(clk), .we(kl_we), .waddr(kl_wa), .wdata(kl_wd), .raddr(kl_ra), .rdata(kl_q));
  hltc_ram #(.WIDTH(KW), .DEPTH(hltc_pkg::ENTRIES)) u_kh (
    .clk(clk), .we(kh_we), .waddr(kh_wa), .wdata(kh_wd), .raddr(kh_ra), .rdata(kh_q));
  hltc_ram #(.WIDTH(EW), .DEPTH(hltc_pkg::ENTRIES)) u_cn (
    .clk(clk), .we(cn_we), .waddr(cn_wa), .wdata(cn_wd), .raddr(cn_ra), .rdata(cn_q));
  hltc_ram #(.WIDTH(EW), .DEPTH(hltc_pkg::ENTRIES)) u_rn (
    .clk(clk), .we(rn_we), .waddr(rn_wa), .wdata(rn_wd), .raddr(rn_ra), .rdata(rn_q));
  hltc_ram #(.WIDTH(EW), .DEPTH(hltc_pkg::ENTRIES)) u_rp (
    .clk(clk), .we(rp_we), .waddr(rp_wa), .wdata(rp_wd), .raddr(rp_ra), .rdata(rp_q));
  hltc_ram #(.WIDTH(UW), .DEPTH(hltc_pkg::ENTRIES)) u_us (
    .clk(clk), .we(us_we), .waddr(us_wa), .wdata(us_wd), .raddr(us_ra), .rdata(us_q));
  hltc_ram #(.WIDTH(UW), .DEPTH(hltc_pkg::ENTRIES)) u_uc (
    .clk(clk), .we(uc_we), .waddr(uc_wa), .wdata(uc_wd), .raddr(uc_ra), .rdata(uc_q));

  hltc_div u_div (
    .clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    reserved_nxt = reserved_r;
    per_row_nxt  = per_row_r;
    if (cfg_we) begin
      case (cfg_index)
        hltc_pkg::CFG_RESERVED: reserved_nxt = cfg_wdata;
        hltc_pkg::CFG_PER_ROW:  per_row_nxt  = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    init_nxt      = init_r;
    key_lo_nxt    = key_lo_r;
    key_hi_nxt    = key_hi_r;
    bkt_nxt       = bkt_r;
    bkt2_nxt      = bkt2_r;
    e_nxt         = e_r;
    t_nxt         = t_r;
    ct_nxt        = ct_r;
    c_nxt         = c_r;
    fnext_nxt     = fnext_r;
    head_nxt      = head_r;
    steps_nxt     = steps_r;
    hit_nxt       = hit_r;
    ev_nxt        = ev_r;
    us_nxt        = us_r;
    uc_nxt        = uc_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    bh_we = 1'b0; bh_wa = bkt_r; bh_wd = '0; bh_ra = bkt_r;
    kl_we = 1'b0; kl_wa = e_r; kl_wd = key_lo_r; kl_ra = e_r;
    kh_we = 1'b0; kh_wa = e_r; kh_wd = key_hi_r; kh_ra = e_r;
    cn_we = 1'b0; cn_wa = e_r; cn_wd = '0; cn_ra = e_r;
    rn_we = 1'b0; rn_wa = e_r; rn_wd = '0; rn_ra = e_r;
    rp_we = 1'b0; rp_wa = e_r; rp_wd = '0; rp_ra = e_r;
    us_we = 1'b0; us_wa = e_r; us_wd = '0; us_ra = e_r;
    uc_we = 1'b0; uc_wa = e_r; uc_wd = '0; uc_ra = e_r;

    div_req.start    = 1'b0;
    div_req.dividend = hltc_pkg::POS_W'(reserved_r) + hltc_pkg::POS_W'(e_r);
    div_req.divisor  = (per_row_r == 16'd0) ? 16'd1 : per_row_r;

    case (state_r)
      S_INIT: begin
        if ({1'b0, init_r} < (hltc_pkg::CLR_W + 1)'(hltc_pkg::ENTRIES)) begin
          cn_we = 1'b1; rn_we = 1'b1; rp_we = 1'b1; us_we = 1'b1; uc_we = 1'b1;
          cn_wa = init_r[EW-1:0];
          rn_wa = init_r[EW-1:0];
          rp_wa = init_r[EW-1:0];
          us_wa = init_r[EW-1:0];
          uc_wa = init_r[EW-1:0];
          if (init_r == hltc_pkg::CLR_W'(hltc_pkg::ENTRIES - 1)) begin
            cn_wd = '0;
          end else begin
            cn_wd = EW'(init_r + 1'b1);
          end
        end
        if ({1'b0, init_r} < (hltc_pkg::CLR_W + 1)'(hltc_pkg::BUCKETS)) begin
          bh_we = 1'b1;
          bh_wa = init_r[BW-1:0];
        end
        init_nxt = init_r + 1'b1;
        if (init_r == hltc_pkg::CLR_W'(hltc_pkg::CLR_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        bh_ra = in_data.key_low[BW-1:0];
        if (in_valid) begin
          if (in_data.opcode == hltc_pkg::OP_WRITE) begin
            if ({1'b0, in_data.target_entry} < 9'(hltc_pkg::ENTRIES)) begin
              us_we = 1'b1; uc_we = 1'b1;
              us_wa = EW'(in_data.target_entry);
              uc_wa = EW'(in_data.target_entry);
              us_wd = in_data.new_state;
              uc_wd = in_data.new_count;
            end
          end else begin
            key_lo_nxt = in_data.key_low;
            key_hi_nxt = in_data.key_high;
            bkt_nxt    = in_data.key_low[BW-1:0];
            steps_nxt  = '0;
            hit_nxt    = 1'b0;
            ev_nxt     = 1'b0;
            state_nxt  = S_HEADW;
          end
        end
      end
      S_HEADW: begin
        e_nxt     = bh_q;
        state_nxt = S_PROBE;
      end
      S_PROBE: begin
        if (e_r == '0 || steps_r == hltc_pkg::STEP_W'(hltc_pkg::ENTRIES)) begin
          state_nxt = S_MISS;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (kl_q == key_lo_r && kh_q == key_hi_r) begin
          hit_nxt   = 1'b1;
          state_nxt = S_HIT;
        end else begin
          e_nxt     = cn_q;
          steps_nxt = steps_r + 1'b1;
          state_nxt = S_PROBE;
        end
      end
      S_HIT: begin
        state_nxt = S_UNL;
      end
      S_UNL: begin
        us_nxt = us_q;
        uc_nxt = uc_q;
        rn_we  = 1'b1; rn_wa = rp_q; rn_wd = rn_q;
        rp_we  = 1'b1; rp_wa = rn_q; rp_wd = rp_q;
        state_nxt = S_MRU;
      end
      S_MISS: begin
        cn_ra     = '0;
        state_nxt = S_FREEW;
      end
      S_FREEW: begin
        if (cn_q == '0) begin
          ev_nxt    = 1'b1;
          state_nxt = S_EV0;
        end else begin
          e_nxt     = cn_q;
          cn_ra     = cn_q;
          state_nxt = S_FREEN;
        end
      end
      S_FREEN: begin
        fnext_nxt = cn_q;
        state_nxt = S_ALLOC;
      end
      S_EV0: begin
        rp_ra     = '0;
        state_nxt = S_EV1;
      end
      S_EV1: begin
        if (rp_q == '0) begin
          state_nxt = S_IDLE;
        end else begin
          t_nxt     = rp_q;
          rp_ra     = rp_q;
          kl_ra     = rp_q;
          cn_ra     = rp_q;
          state_nxt = S_EV2;
        end
      end
      S_EV2: begin
        rn_we    = 1'b1; rn_wa = rp_q; rn_wd = '0;
        rp_we    = 1'b1; rp_wa = '0;   rp_wd = rp_q;
        bkt2_nxt = kl_q[BW-1:0];
        ct_nxt   = cn_q;
        bh_ra    = kl_q[BW-1:0];
        state_nxt = S_EV3;
      end
      S_EV3: begin
        e_nxt     = t_r;
        fnext_nxt = '0;
        if (bh_q == t_r) begin
          bh_we     = 1'b1; bh_wa = bkt2_r; bh_wd = ct_r;
          state_nxt = S_ALLOC;
        end else begin
          c_nxt     = bh_q;
          steps_nxt = '0;
          state_nxt = S_EVWALK;
        end
      end
      S_EVWALK: begin
        cn_ra = c_r;
        if (c_r == '0) begin
          state_nxt = S_ALLOC;
        end else begin
          state_nxt = S_EVWALKW;
        end
      end
      S_EVWALKW: begin
        if (cn_q == t_r) begin
          cn_we     = 1'b1; cn_wa = c_r; cn_wd = ct_r;
          state_nxt = S_ALLOC;
        end else if (steps_r == hltc_pkg::STEP_W'(hltc_pkg::ENTRIES)) begin
          state_nxt = S_ALLOC;
        end else begin
          c_nxt     = cn_q;
          steps_nxt = steps_r + 1'b1;
          state_nxt = S_EVWALK;
        end
      end
      S_ALLOC: begin
        cn_we     = 1'b1; cn_wa = '0; cn_wd = fnext_r;
        bh_ra     = bkt_r;
        state_nxt = S_ALLOCW;
      end
      S_ALLOCW: begin
        cn_we = 1'b1; cn_wd = bh_q;
        bh_we = 1'b1; bh_wa = bkt_r; bh_wd = e_r;
        kl_we = 1'b1;
        kh_we = 1'b1;
        us_we = 1'b1;
        uc_we = 1'b1;
        us_nxt    = '0;
        uc_nxt    = '0;
        state_nxt = S_MRU;
      end
      S_MRU: begin
        rn_ra     = '0;
        state_nxt = S_MRUW;
      end
      S_MRUW: begin
        head_nxt  = rn_q;
        rn_we     = 1'b1; rn_wd = rn_q;
        rp_we     = 1'b1; rp_wd = '0;
        state_nxt = S_MRU2;
      end
      S_MRU2: begin
        rp_we     = 1'b1; rp_wa = head_r; rp_wd = e_r;
        rn_we     = 1'b1; rn_wa = '0;     rn_wd = e_r;
        state_nxt = S_TILE;
      end
      S_TILE: begin
        div_req.start = 1'b1;
        state_nxt     = S_DIVW;
      end
      S_DIVW: begin
        if (div_rsp.done && (!out_valid_r || out_ready)) begin
          out_nxt.entry_id   = 8'(e_r);
          out_nxt.was_hit    = hit_r;
          out_nxt.evicted    = ev_r;
          out_nxt.fill_state = us_r;
          out_nxt.tile_count = uc_r;
          out_nxt.tile_x     = div_rsp.remainder;
          out_nxt.tile_y     = div_rsp.quotient[hltc_pkg::TILE_W-1:0];
          out_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_r      <= '0;
      reserved_r  <= 16'd0;
      per_row_r   <= 16'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      reserved_r  <= reserved_nxt;
      per_row_r   <= per_row_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_lo_r <= key_lo_nxt;
    key_hi_r <= key_hi_nxt;
    bkt_r    <= bkt_nxt;
    bkt2_r   <= bkt2_nxt;
    e_r      <= e_nxt;
    t_r      <= t_nxt;
    ct_r     <= ct_nxt;
    c_r      <= c_nxt;
    fnext_r  <= fnext_nxt;
    head_r   <= head_nxt;
    steps_r  <= steps_nxt;
    hit_r    <= hit_nxt;
    ev_r     <= ev_nxt;
    us_r     <= us_nxt;
    uc_r     <= uc_nxt;
    out_r    <= out_nxt;
  end

endmodule

>>> src/hltc_ram.sv
// ----------------------------------------------------------------------------
// Tile cache RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module hltc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/hltc_div.sv
// ----------------------------------------------------------------------------
// Tile cache divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hltc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  hltc_pkg::div_req_t req,
  output hltc_pkg::div_rsp_t rsp
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [hltc_pkg::DCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [hltc_pkg::POS_W-1:0]    dvd_r, dvd_nxt;
  logic [hltc_pkg::TILE_W-1:0]   rem_r, rem_nxt;
  logic [hltc_pkg::TILE_W-1:0]   dsr_r, dsr_nxt;
  logic [hltc_pkg::TILE_W:0]     shifted;
  logic [hltc_pkg::TILE_W:0]     diff;

  always_comb begin
    shifted  = {rem_r, dvd_r[hltc_pkg::POS_W-1]};
    diff     = shifted - {1'b0, dsr_r};
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = '0;
      dvd_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      if (!diff[hltc_pkg::TILE_W]) begin
        rem_nxt = diff[hltc_pkg::TILE_W-1:0];
        dvd_nxt = {dvd_r[hltc_pkg::POS_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[hltc_pkg::TILE_W-1:0];
        dvd_nxt = {dvd_r[hltc_pkg::POS_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == hltc_pkg::DCNT_W'(hltc_pkg::POS_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = dvd_r;
  assign rsp.remainder = rem_r;

endmodule

>>> tb/hashed_lru_tile_cache_test.sv
// ----------------------------------------------------------------------------
// Hashed LRU tile cache testbench
// Drives lookup and entry-write words with random idling, predicts each lookup
// result from a behavioral cache model and compares it field by field.
// ----------------------------------------------------------------------------
module hashed_lru_tile_cache_test;

  class tile_cache_scoreboard;
    logic [7:0]  bucket_head [hltc_pkg::BUCKETS];
    logic [63:0] key_lo [hltc_pkg::ENTRIES];
    logic [63:0] key_hi [hltc_pkg::ENTRIES];
    logic [7:0]  chain_nxt [hltc_pkg::ENTRIES];
    logic [7:0]  lru_nxt [hltc_pkg::ENTRIES];
    logic [7:0]  lru_prv [hltc_pkg::ENTRIES];
    logic [31:0] ustate [hltc_pkg::ENTRIES];
    logic [31:0] ucount [hltc_pkg::ENTRIES];
    logic [15:0] reserved;
    logic [15:0] per_row;
    hltc_pkg::out_word_t pending [$];
    int          errors;

    function new();
      for (int i = 0; i < hltc_pkg::BUCKETS; i++) bucket_head[i] = '0;
      for (int i = 0; i < hltc_pkg::ENTRIES; i++) begin
        key_lo[i] = '0;
        key_hi[i] = '0;
        chain_nxt[i] = (i + 1 < hltc_pkg::ENTRIES) ? 8'(i + 1) : 8'd0;
        lru_nxt[i] = '0;
        lru_prv[i] = '0;
        ustate[i] = '0;
        ucount[i] = '0;
      end
      reserved = 16'd0;
      per_row = 16'd1;
      errors = 0;
    endfunction

    function void set_reg(logic idx, logic [15:0] v);
      if (idx == hltc_pkg::CFG_RESERVED) reserved = v;
      else per_row = v;
    endfunction

    function int bucket_of(logic [63:0] kl);
      return int'(kl[31:0] % hltc_pkg::BUCKETS);
    endfunction

    function void evict_tail();
      int t, b, c, steps;
      t = lru_prv[0];
      if (t == 0) return;
      lru_nxt[lru_prv[t]] = '0;
      lru_prv[0] = lru_prv[t];
      b = bucket_of(key_lo[t]);
      if (bucket_head[b] == t) begin
        bucket_head[b] = chain_nxt[t];
      end else begin
        c = bucket_head[b];
        steps = 0;
        while (c != 0 && chain_nxt[c] != t && steps < hltc_pkg::ENTRIES) begin
          c = chain_nxt[c];
          steps++;
        end
        if (c != 0 && chain_nxt[c] == t) chain_nxt[c] = chain_nxt[t];
      end
      chain_nxt[t] = chain_nxt[0];
      chain_nxt[0] = 8'(t);
      ustate[t] = '0;
      ucount[t] = '0;
    endfunction

    function void note_word(hltc_pkg::in_word_t w);
      int b, e, steps, hd;
      logic [31:0] pos, tpr;
      bit hit, ev;
      hltc_pkg::out_word_t r;
      hit = 0;
      ev = 0;
      if (w.opcode == hltc_pkg::OP_WRITE) begin
        ustate[w.target_entry] = w.new_state;
        ucount[w.target_entry] = w.new_count;
        return;
      end
      b = bucket_of(w.key_low);
      e = bucket_head[b];
      steps = 0;
      while (e != 0 && steps < hltc_pkg::ENTRIES) begin
        if (key_lo[e] == w.key_low && key_hi[e] == w.key_high) begin
          hit = 1;
          break;
        end
        e = chain_nxt[e];
        steps++;
      end
      if (hit) begin
        lru_nxt[lru_prv[e]] = lru_nxt[e];
        lru_prv[lru_nxt[e]] = lru_prv[e];
      end else begin
        if (chain_nxt[0] == 0) begin
          evict_tail();
          ev = 1;
        end
        e = chain_nxt[0];
        chain_nxt[0] = chain_nxt[e];
        chain_nxt[e] = bucket_head[b];
        bucket_head[b] = 8'(e);
        key_lo[e] = w.key_low;
        key_hi[e] = w.key_high;
        ustate[e] = '0;
        ucount[e] = '0;
      end
      hd = lru_nxt[0];
      lru_nxt[e] = 8'(hd);
      lru_prv[e] = '0;
      lru_prv[hd] = 8'(e);
      lru_nxt[0] = 8'(e);
      tpr = (per_row == 16'd0) ? 32'd1 : {16'd0, per_row};
      pos = {16'd0, reserved} + 32'(e);
      r.entry_id = 8'(e);
      r.was_hit = hit;
      r.evicted = ev;
      r.fill_state = ustate[e];
      r.tile_count = ucount[e];
      r.tile_x = 16'(pos % tpr);
      r.tile_y = 16'(pos / tpr);
      pending.push_back(r);
    endfunction

    function void check_word(hltc_pkg::out_word_t a);
      hltc_pkg::out_word_t x;
      if (pending.size() == 0) begin
        $error("unexpected result word entry_id=%0d", a.entry_id);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (a.entry_id !== x.entry_id) begin
        $error("entry_id exp %0d got %0d", x.entry_id, a.entry_id); errors++;
      end
      if (a.was_hit !== x.was_hit) begin
        $error("was_hit exp %0d got %0d", x.was_hit, a.was_hit); errors++;
      end
      if (a.evicted !== x.evicted) begin
        $error("evicted exp %0d got %0d", x.evicted, a.evicted); errors++;
      end
      if (a.fill_state !== x.fill_state) begin
        $error("fill_state exp %h got %h", x.fill_state, a.fill_state); errors++;
      end
      if (a.tile_count !== x.tile_count) begin
        $error("tile_count exp %h got %h", x.tile_count, a.tile_count); errors++;
      end
      if (a.tile_x !== x.tile_x) begin
        $error("tile_x exp %0d got %0d", x.tile_x, a.tile_x); errors++;
      end
      if (a.tile_y !== x.tile_y) begin
        $error("tile_y exp %0d got %0d", x.tile_y, a.tile_y); errors++;
      end
    endfunction
  endclass

  logic                clk = 0;
  logic                rst_n = 0;
  logic                in_valid = 0;
  logic                in_ready;
  hltc_pkg::in_word_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 0;
  hltc_pkg::out_word_t out_data;
  logic                cfg_we = 0;
  logic                cfg_index = hltc_pkg::CFG_RESERVED;
  logic [15:0]         cfg_wdata = 0;

  tile_cache_scoreboard sb = new();
  bit    quiet = 0;
  bit    hold_off = 0;
  int    idle_cycles = 0;
  logic [63:0] recent_lo [$];
  logic [63:0] recent_hi [$];

  localparam int WATCHDOG = 20000;

  always #1 clk = ~clk;

  hashed_lru_tile_cache u_dut (.*);

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_word(in_data);
    if (rst_n && out_valid && out_ready) sb.check_word(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("hashed_lru_tile_cache_test: errors");
      $finish;
    end
  end

  // Result side: random stall bursts, or one long hold-off on request.
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (hold_off) begin
        out_ready <= 0;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        n = $urandom_range(1, 3);
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1;
        @(posedge clk);
      end
    end
  end

  // Valid stays high between back-to-back words and drops only for idling.
  task automatic send_word(hltc_pkg::in_word_t w);
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      n = $urandom_range(1, 3);
      repeat (n) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic lookup(logic [63:0] kl, logic [63:0] kh);
    hltc_pkg::in_word_t w;
    w = '0;
    w.opcode = hltc_pkg::OP_LOOKUP;
    w.key_low = kl;
    w.key_high = kh;
    w.target_entry = 8'($urandom);
    w.new_state = $urandom;
    w.new_count = $urandom;
    send_word(w);
    recent_lo.push_back(kl);
    recent_hi.push_back(kh);
    if (recent_lo.size() > 40) begin
      void'(recent_lo.pop_front());
      void'(recent_hi.pop_front());
    end
  endtask

  task automatic write_entry(logic [7:0] t, logic [31:0] s, logic [31:0] c);
    hltc_pkg::in_word_t w;
    w = '0;
    w.opcode = hltc_pkg::OP_WRITE;
    w.key_low = {$urandom, $urandom};
    w.key_high = {$urandom, $urandom};
    w.target_entry = t;
    w.new_state = s;
    w.new_count = c;
    send_word(w);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic random_word();
    int k, p;
    logic [63:0] kl, kh;
    k = $urandom_range(0, 9);
    if (k < 4 && recent_lo.size() > 0) begin
      p = $urandom_range(0, recent_lo.size() - 1);
      lookup(recent_lo[p], recent_hi[p]);
    end else if (k < 8) begin
      // Low words restricted to four bucket indices crowd those buckets into long chains.
      kl = {$urandom, 26'h0, 6'($urandom_range(0, 3))};
      if (k == 7) kl = {$urandom, $urandom};
      kh = {$urandom, $urandom};
      lookup(kl, kh);
    end else begin
      write_entry(8'($urandom), $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    write_reg(hltc_pkg::CFG_RESERVED, 16'd0);
    write_reg(hltc_pkg::CFG_PER_ROW, 16'd1);

    lookup('0, '0);
    lookup('1, '1);
    lookup('0, '0);
    lookup('1, '0);
    lookup(64'h0000_0000_0000_0040, 64'h5);
    lookup(64'h0000_0001_0000_0000, 64'h5);
    lookup('1, '1);
    write_entry(8'd1, 32'hffff_ffff, 32'hffff_ffff);
    write_entry(8'd0, 32'h1234, 32'h5678);
    write_entry(8'd255, 32'hdead, 32'hbeef);
    lookup('0, '0);
    lookup(64'h0000_0000_0000_0040, 64'h5);
    write_entry(8'd200, 32'h0, 32'h0);
    drain();

    write_reg(hltc_pkg::CFG_RESERVED, 16'hffff);
    write_reg(hltc_pkg::CFG_PER_ROW, 16'h0);
    lookup('1, '1);
    lookup('0, '0);
    drain();
    write_reg(hltc_pkg::CFG_PER_ROW, 16'hffff);
    lookup('1, '1);
    lookup(64'h0000_0000_0000_0040, 64'h5);
    drain();
    write_reg(hltc_pkg::CFG_RESERVED, 16'd7);
    write_reg(hltc_pkg::CFG_PER_ROW, 16'd3);

    // Random lookups and entry writes; the later ones run under a long result hold-off.
    for (int i = 0; i < 150; i++) random_word();
    hold_off = 1;
    for (int i = 0; i < 10; i++) random_word();
    drain();
    write_reg(hltc_pkg::CFG_RESERVED, 16'($urandom));
    write_reg(hltc_pkg::CFG_PER_ROW, 16'($urandom_range(1, 40)));
    for (int i = 0; i < 150; i++) random_word();
    drain();
    write_reg(hltc_pkg::CFG_PER_ROW, 16'($urandom_range(1, 65535)));
    quiet = 1;
    for (int i = 0; i < 120; i++) random_word();
    drain();
    if (sb.errors == 0) begin
      $display("hashed_lru_tile_cache_test: clean");
    end else begin
      $display("hashed_lru_tile_cache_test: errors");
    end
    $finish;
  end
endmodule

>>> hashed_lru_tile_cache.f
src/hltc_pkg.sv
src/hltc_ram.sv
src/hltc_div.sv
src/hashed_lru_tile_cache.sv
tb/hashed_lru_tile_cache_test.sv
